[rtl/lzc_pkg.sv]
// Shared types and constants for the 12-bit dictionary compressor.
// No dependencies; the compressor core imports this package.
package lzc_pkg;

  // Default code width and dictionary size (prime, so double hashing reaches every slot).
  localparam int unsigned CODE_BITS_DEF     = 12;
  localparam int unsigned TABLE_ENTRIES_DEF = 5021;

  // Stream header bytes; the third one is the code width with the block flag set.
  localparam logic [7:0] HDR_0      = 8'h1F;
  localparam logic [7:0] HDR_1      = 8'h9D;
  localparam logic [7:0] BLOCK_FLAG = 8'h80;

  // First code handed out to a new dictionary entry.
  localparam int unsigned FIRST_FREE = 257;

  // Depth of the output byte queue (power of two).
  localparam int unsigned FIFO_DEPTH = 8;

  // One compressed output byte with its framing flags.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HDR,
    S_CHECK,
    S_LOAD,
    S_PUSH
  } lzc_state_e;

endpackage

[rtl/lzc_stream_if.sv]
// Valid/ready stream interfaces for the compressor's raw input and compressed output.
// No dependencies.
interface lzc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lzc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, output out_byte, output last_of_run, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input stream_done,
                  output ready);
endinterface

[rtl/lzw_compressor_12bit_core.sv]
// Dictionary compressor core, fixed-width codes; depends on lzc_pkg and lzc_stream_if.
// Flow: a byte absorbed into a match passes from S_IDLE through one or more probes in S_CHECK;
// a byte that ends a string then goes through S_LOAD and S_PUSH for each code it emits (1 or 2
// code bytes each); a stream's first byte sends three header bytes from S_HDR instead.
// New input is taken only in S_IDLE. A full output queue stalls S_HDR and S_PUSH.
// Reset (async, active low) and each end of stream clear the dictionary, one slot at a time.
module lzw_compressor_12bit_core #(
  parameter int unsigned CODE_BITS     = lzc_pkg::CODE_BITS_DEF,
  parameter int unsigned TABLE_ENTRIES = lzc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzc_in_if.sink    in_i,
  lzc_out_if.source out_o
);
  import lzc_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned TW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PW  = CODE_BITS + 7;
  localparam int unsigned CW  = $clog2(CODE_BITS + 8);
  localparam int unsigned PTW = $clog2(FIFO_DEPTH);
  localparam int unsigned FCW = $clog2(FIFO_DEPTH + 1);

  localparam logic [CODE_BITS-1:0] TOP_CODE   = CODE_BITS'((1 << CODE_BITS) - 2);
  localparam logic [CODE_BITS-1:0] FIRST_CODE = CODE_BITS'(FIRST_FREE);
  localparam logic [AW-1:0]        T_AW       = AW'(TABLE_ENTRIES);
  localparam logic [AW-1:0]        LAST_SLOT  = AW'(TABLE_ENTRIES - 1);
  localparam logic [TW-1:0]        LAST_TRY   = TW'(TABLE_ENTRIES - 1);
  localparam logic [1:0]           HDR_LAST   = 2'd2;

  // One dictionary slot: valid flag, assigned code, and the (prefix, byte) key.
  typedef struct packed {
    logic                 valid;
    logic [CODE_BITS-1:0] code;
    logic [CODE_BITS-1:0] prefix;
    logic [7:0]           ch;
  } entry_t;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  lzc_state_e           state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;          // clearing pass address
  logic [CODE_BITS-1:0] cur_q, cur_d;          // code of the current string
  logic [CODE_BITS-1:0] nfc_q, nfc_d;          // next free code
  logic                 started_q, started_d;  // header already sent
  logic [PW-1:0]        buf_q, buf_d;          // bit packer, LSB first
  logic [CW-1:0]        cnt_q, cnt_d;          // bits held in the packer
  logic [1:0]           hdr_q, hdr_d;          // header byte index
  logic [1:0]           left_q, left_d;        // codes still to pack after code_q
  logic                 eos_q, eos_d;
  logic [TW-1:0]        tries_q, tries_d;      // probes done in this lookup

  logic [7:0]           ch_q, ch_d;            // byte of the transaction in flight
  logic [AW-1:0]        idx_q, idx_d;          // slot being probed
  logic [AW-1:0]        step_q, step_d;        // double-hashing stride
  logic [CODE_BITS-1:0] code_q, code_d;        // code waiting to be packed

  // Dictionary RAM, one read and one write port, registered read data.
  entry_t               dict_mem [TABLE_ENTRIES];
  entry_t               rd_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  entry_t               mem_wdata;

  // Output byte queue: decouples the packer from a stalled sink.
  out_item_t            fifo_q [FIFO_DEPTH];
  logic [PTW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [FCW-1:0]       fcnt_q;
  logic                 push_en;
  out_item_t            push_item;

  // ---------------------------------------------------------------------------
  // Shared conditions
  // ---------------------------------------------------------------------------
  logic                 accept_c, pop_c, fifo_full_c, hit_c, empty_c, exhaust_c, code_end_c;
  logic [CODE_BITS-1:0] hash_c;
  logic [AW-1:0]        hidx_c, hstep_c, nidx_c;

  assign in_i.ready  = (state_q == S_IDLE);
  assign accept_c    = in_i.valid && in_i.ready;
  assign pop_c       = out_o.valid && out_o.ready;
  assign fifo_full_c = (fcnt_q == FCW'(FIFO_DEPTH));

  // The hashed key is below 2^CODE_BITS, which never exceeds TABLE_ENTRIES, so the
  // modulo of the hash is the key itself.
  assign hash_c  = (CODE_BITS'(in_i.in_byte) << (CODE_BITS - 8)) ^ cur_q;
  assign hidx_c  = AW'(hash_c);
  assign hstep_c = (hidx_c == '0) ? AW'(1) : (T_AW - hidx_c);
  // Step backwards by the stride, wrapping around the table.
  assign nidx_c  = (idx_q < step_q) ? (idx_q + (T_AW - step_q)) : (idx_q - step_q);

  assign hit_c      = rd_q.valid && (rd_q.prefix == cur_q) && (rd_q.ch == ch_q);
  assign empty_c    = !rd_q.valid;
  assign exhaust_c  = (tries_q == LAST_TRY);
  // After this byte fewer than 8 bits remain: the current code is fully drained.
  assign code_end_c = (cnt_q < CW'(16));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_SLOT) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept_c) state_d = started_q ? S_CHECK : S_HDR;
      end
      S_HDR: begin
        if (!fifo_full_c && (hdr_q == HDR_LAST)) state_d = eos_q ? S_LOAD : S_IDLE;
      end
      S_CHECK: begin
        if (hit_c) begin
          state_d = eos_q ? S_LOAD : S_IDLE;
        end else if (empty_c || exhaust_c) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!fifo_full_c && code_end_c) begin
          if (left_q != '0) begin
            state_d = S_LOAD;
          end else begin
            state_d = eos_q ? S_CLEAR : S_IDLE;
          end
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    clr_d     = clr_q;
    cur_d     = cur_q;
    nfc_d     = nfc_q;
    started_d = started_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    hdr_d     = hdr_q;
    left_d    = left_q;
    eos_d     = eos_q;
    tries_d   = tries_q;
    ch_d      = ch_q;
    idx_d     = idx_q;
    step_d    = step_q;
    code_d    = code_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_q;
    mem_raddr = hidx_c;
    mem_wdata = '0;
    push_en   = 1'b0;
    push_item = '0;

    unique case (state_q)
      S_CLEAR: begin
        // Sweep the table, dropping every valid flag.
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
      end

      S_IDLE: begin
        if (accept_c) begin
          ch_d  = in_i.in_byte;
          eos_d = in_i.end_of_stream;
          if (!started_q) begin
            // First byte of a stream: it becomes the current string.
            cur_d     = CODE_BITS'(in_i.in_byte);
            started_d = 1'b1;
            hdr_d     = '0;
          end else begin
            // Launch the first probe at the hashed slot.
            idx_d     = hidx_c;
            step_d    = hstep_c;
            tries_d   = '0;
            mem_re    = 1'b1;
            mem_raddr = hidx_c;
          end
        end
      end

      S_HDR: begin
        if (!fifo_full_c) begin
          push_en = 1'b1;
          case (hdr_q)
            2'd0:    push_item.out_byte = HDR_0;
            2'd1:    push_item.out_byte = HDR_1;
            default: push_item.out_byte = 8'(CODE_BITS) | BLOCK_FLAG;
          endcase
          push_item.last_of_run = (hdr_q == HDR_LAST) && !eos_q;
          hdr_d = hdr_q + 2'd1;
          if ((hdr_q == HDR_LAST) && eos_q) begin
            // Single-byte stream: pack its code, then the zero code.
            code_d = cur_q;
            left_d = 2'd1;
          end
        end
      end

      S_CHECK: begin
        if (hit_c) begin
          // Extend the string; nothing to emit unless the stream ends here.
          cur_d = rd_q.code;
          if (eos_q) begin
            code_d = rd_q.code;
            left_d = 2'd1;
          end
        end else if (empty_c || exhaust_c) begin
          // Miss: add the new string if there is room and a free slot.
          if (empty_c && (nfc_q <= TOP_CODE)) begin
            mem_we    = 1'b1;
            mem_waddr = idx_q;
            mem_wdata = '{valid: 1'b1, code: nfc_q, prefix: cur_q, ch: ch_q};
            nfc_d     = nfc_q + CODE_BITS'(1);
          end
          code_d = cur_q;
          cur_d  = CODE_BITS'(ch_q);
          left_d = eos_q ? 2'd2 : 2'd0;
        end else begin
          // Collision: advance to the next slot of the probe sequence.
          idx_d     = nidx_c;
          tries_d   = tries_q + TW'(1);
          mem_re    = 1'b1;
          mem_raddr = nidx_c;
        end
      end

      S_LOAD: begin
        buf_d = buf_q | (PW'(code_q) << cnt_q);
        cnt_d = cnt_q + CW'(CODE_BITS);
      end

      S_PUSH: begin
        if (!fifo_full_c) begin
          push_en               = 1'b1;
          push_item.out_byte    = buf_q[7:0];
          push_item.last_of_run = code_end_c && (left_q == '0);
          push_item.stream_done = code_end_c && (left_q == '0) && eos_q;
          buf_d = buf_q >> 8;
          cnt_d = cnt_q - CW'(8);
          if (code_end_c) begin
            if (left_q != '0) begin
              // Next code: the final string code, then the zero code.
              code_d = (left_q == 2'd2) ? cur_q : '0;
              left_d = left_q - 2'd1;
            end else if (eos_q) begin
              // End of stream: drop leftover bits and restart the dictionary.
              nfc_d     = FIRST_CODE;
              cur_d     = '0;
              started_d = 1'b0;
              buf_d     = '0;
              cnt_d     = '0;
              clr_d     = '0;
            end
          end
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      cur_q     <= '0;
      nfc_q     <= FIRST_CODE;
      started_q <= 1'b0;
      buf_q     <= '0;
      cnt_q     <= '0;
      hdr_q     <= '0;
      left_q    <= '0;
      eos_q     <= 1'b0;
      tries_q   <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cur_q     <= cur_d;
      nfc_q     <= nfc_d;
      started_q <= started_d;
      buf_q     <= buf_d;
      cnt_q     <= cnt_d;
      hdr_q     <= hdr_d;
      left_q    <= left_d;
      eos_q     <= eos_d;
      tries_q   <= tries_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    idx_q  <= idx_d;
    step_q <= step_d;
    code_q <= code_d;
  end

  // Dictionary RAM. A slot written on a miss is read again no earlier than the next
  // transaction, after S_LOAD and S_PUSH, so no forwarding path is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) dict_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= dict_mem[mem_raddr];
  end

  // Output queue
  always_ff @(posedge clk_i) begin
    if (push_en) fifo_q[wr_ptr_q] <= push_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      if (push_en) wr_ptr_q <= wr_ptr_q + PTW'(1);
      if (pop_c)   rd_ptr_q <= rd_ptr_q + PTW'(1);
      case ({push_en, pop_c})
        2'b10:   fcnt_q <= fcnt_q + FCW'(1);
        2'b01:   fcnt_q <= fcnt_q - FCW'(1);
        default: fcnt_q <= fcnt_q;
      endcase
    end
  end

  assign out_o.valid       = (fcnt_q != '0);
  assign out_o.out_byte    = fifo_q[rd_ptr_q].out_byte;
  assign out_o.last_of_run = fifo_q[rd_ptr_q].last_of_run;
  assign out_o.stream_done = fifo_q[rd_ptr_q].stream_done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |-> (fcnt_q < FCW'(FIFO_DEPTH)))
    else $error("output queue overflow");

  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("dictionary read and write in the same cycle");

  a_pack_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q < CW'(8)))
    else $error("packer holds a full byte while idle");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en && push_item.stream_done) |-> push_item.last_of_run)
    else $error("stream end flagged on a byte that is not last of its run");

  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CLEAR) && (clr_q == LAST_SLOT)) |=> ((state_q == S_IDLE) && !started_q))
    else $error("clearing pass did not return to a fresh stream");

endmodule
